@@ hw/rtl/bmp24_stream_decoder_macros.svh @@
// Assertion helpers shared by the decoder files.
`ifndef BMP24_STREAM_DECODER_MACROS_SVH
`define BMP24_STREAM_DECODER_MACROS_SVH

// Checked on every clock edge outside reset.
`define BMP24_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BMP24_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/bmp24_pkg.sv @@
`timescale 1ns / 1ps

package bmp24_pkg;

   // Image limits and header layout.
   localparam int MAX_WIDTH = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int HEADER_BYTES = 54;
   localparam int SIG_FIRST_POS = 0;
   localparam int SIG_SECOND_POS = 1;
   localparam int WIDTH_POS = 18;
   localparam int HEIGHT_POS = 22;
   localparam int FIELD_BYTES = 4;
   localparam int ROW_ALIGN = 4;

   localparam logic [7:0] SIG_B = 8'h42;
   localparam logic [7:0] SIG_M = 8'h4D;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Derived widths.
   localparam int HDR_CNT_BITS = $clog2(HEADER_BYTES + 1);
   localparam int W_BITS = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int POS_BITS = $clog2(3 * MAX_WIDTH + ROW_ALIGN);
   localparam int IDX_BITS = 24;

   typedef enum logic [1:0] {
      STATUS_PIXEL = 2'd0,
      STATUS_BAD_SIGNATURE = 2'd1,
      STATUS_BAD_SIZE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PIXELS = 2'd1,
      PH_IDLE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      COMP_BLUE = 2'd0,
      COMP_GREEN = 2'd1,
      COMP_RED = 2'd2
   } comp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic file_start;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [31:0] pixel_word;
      logic [IDX_BITS-1:0] pixel_index;
      logic last_pixel;
   } rsp_type;

   // Parser result for the byte accepted in this cycle.
   typedef struct packed {
      logic produced;
      rsp_type item;
   } parse_out_type;

endpackage

@@ hw/rtl/bmp24_stream_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Ports                            Moves
// request   req_valid, req_stall, req_data   one file byte and its start flag
// result    rsp_valid, rsp_stall, rsp_data   one pixel or error result
//
// One byte is accepted per cycle while req_stall is low; its result, if any, appears in the next cycle.
// The parser works out each result combinationally, straight into the result register.
// Reset is synchronous and returns the parser to the start of a header.
// req_stall is high only while a result waits and rsp_stall holds it.
module bmp24_stream_decoder (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input bmp24_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output bmp24_pkg::rsp_type rsp_data
);
   import bmp24_pkg::*;

   `include "bmp24_stream_decoder_macros.svh"

   logic req_fire;
   parse_out_type parse_out;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   bmp24_parser u_parser (
      .clock(clock),
      .reset(reset),
      .req_fire(req_fire),
      .req_data(req_data),
      .parse_out(parse_out)
   );

   // Accept a request whenever the result register is free or being emptied.
   always_comb begin
      req_stall = rsp_valid_ff & rsp_stall;
      req_fire = req_valid & ~req_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = parse_out.produced;
         if (parse_out.produced) begin
            rsp_data_in = parse_out.item;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `BMP24_ASSERT(a_result_captured, req_fire && parse_out.produced |=> rsp_valid_ff, "Parser result was not captured")
   `BMP24_ASSERT(a_error_payload_zero, rsp_valid_ff && (rsp_data_ff.status != STATUS_PIXEL) |-> (rsp_data_ff.pixel_word == '0) && (rsp_data_ff.pixel_index == '0) && !rsp_data_ff.last_pixel, "Error result carries a payload")
   `BMP24_ASSERT(a_pixel_alpha, rsp_valid_ff && (rsp_data_ff.status == STATUS_PIXEL) |-> rsp_data_ff.pixel_word[31:24] == ALPHA_OPAQUE, "Pixel alpha is not opaque")

endmodule

@@ hw/rtl/bmp24_parser.sv @@
`timescale 1ns / 1ps

module bmp24_parser (
   input logic clock,
   input logic reset,
   input logic req_fire,
   input bmp24_pkg::req_type req_data,
   output bmp24_pkg::parse_out_type parse_out
);
   import bmp24_pkg::*;

   `include "bmp24_stream_decoder_macros.svh"

   localparam logic [HDR_CNT_BITS-1:0] HDR_LAST = HDR_CNT_BITS'(HEADER_BYTES - 1);
   localparam logic [HDR_CNT_BITS-1:0] SIG1_C = HDR_CNT_BITS'(SIG_FIRST_POS);
   localparam logic [HDR_CNT_BITS-1:0] SIG2_C = HDR_CNT_BITS'(SIG_SECOND_POS);
   localparam logic [HDR_CNT_BITS-1:0] W_POS_C = HDR_CNT_BITS'(WIDTH_POS);
   localparam logic [HDR_CNT_BITS-1:0] W_END_C = HDR_CNT_BITS'(WIDTH_POS + FIELD_BYTES);
   localparam logic [HDR_CNT_BITS-1:0] H_POS_C = HDR_CNT_BITS'(HEIGHT_POS);
   localparam logic [HDR_CNT_BITS-1:0] H_END_C = HDR_CNT_BITS'(HEIGHT_POS + FIELD_BYTES);

   // Control state.
   phase_type phase_ff, phase_in;
   logic [HDR_CNT_BITS-1:0] hcount_ff, hcount_in;
   logic [W_BITS-1:0] width_ff, width_in;
   logic [H_BITS-1:0] height_ff, height_in;
   logic width_big_ff, width_big_in;
   logic height_big_ff, height_big_in;
   logic sig_ok_ff, sig_ok_in;

   // Pixel walk state, set up on the last header byte.
   logic [W_BITS-1:0] column_ff, column_in;
   logic [H_BITS-1:0] file_row_ff, file_row_in;
   logic [POS_BITS-1:0] row_pos_ff, row_pos_in;
   comp_type comp_ff, comp_in;
   logic [7:0] blue_ff, blue_in;
   logic [7:0] green_ff, green_in;
   logic [POS_BITS-1:0] data_bytes_ff, data_bytes_in;
   logic [POS_BITS-1:0] row_bytes_ff, row_bytes_in;
   logic [IDX_BITS-1:0] row_base_ff, row_base_in;
   logic [W_BITS-1:0] last_col_ff, last_col_in;
   logic [H_BITS-1:0] last_row_ff, last_row_in;

   // Working values.
   phase_type phase_cur;
   logic [HDR_CNT_BITS-1:0] hcount_cur;
   logic [W_BITS-1:0] width_cur;
   logic [H_BITS-1:0] height_cur;
   logic width_big_cur, height_big_cur, sig_ok_cur;
   logic [HDR_CNT_BITS-1:0] w_off, h_off;
   logic [31:0] w_shift, h_shift;
   logic [POS_BITS-1:0] w_ext, data_bytes, data_plus;
   logic [W_BITS+H_BITS-1:0] base_prod;
   logic [POS_BITS-1:0] row_pos_nx;
   logic size_bad, is_last;
   logic [7:0] b;

   // Next state and the result for the accepted byte.
   always_comb begin
      phase_in = phase_ff;
      hcount_in = hcount_ff;
      width_in = width_ff;
      height_in = height_ff;
      width_big_in = width_big_ff;
      height_big_in = height_big_ff;
      sig_ok_in = sig_ok_ff;
      column_in = column_ff;
      file_row_in = file_row_ff;
      row_pos_in = row_pos_ff;
      comp_in = comp_ff;
      blue_in = blue_ff;
      green_in = green_ff;
      data_bytes_in = data_bytes_ff;
      row_bytes_in = row_bytes_ff;
      row_base_in = row_base_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      parse_out = '0;
      parse_out.item.status = STATUS_PIXEL;

      b = req_data.data_byte;

      // A start flag restarts the header parse on this very byte.
      phase_cur = req_data.file_start ? PH_HEADER : phase_ff;
      hcount_cur = req_data.file_start ? '0 : hcount_ff;
      width_cur = req_data.file_start ? '0 : width_ff;
      height_cur = req_data.file_start ? '0 : height_ff;
      width_big_cur = req_data.file_start ? 1'b0 : width_big_ff;
      height_big_cur = req_data.file_start ? 1'b0 : height_big_ff;
      sig_ok_cur = req_data.file_start ? 1'b0 : sig_ok_ff;

      // Little-endian size bytes placed at their bit position.
      w_off = hcount_cur - W_POS_C;
      h_off = hcount_cur - H_POS_C;
      w_shift = 32'(b) << {w_off[1:0], 3'b000};
      h_shift = 32'(b) << {h_off[1:0], 3'b000};

      size_bad = width_big_cur || height_big_cur || (width_cur == '0) ||
                 (height_cur == '0) || (width_cur > W_BITS'(MAX_WIDTH)) ||
                 (height_cur > H_BITS'(MAX_HEIGHT));

      // Row geometry: three bytes a pixel, rows padded to a multiple of four bytes.
      w_ext = POS_BITS'(width_cur);
      data_bytes = (w_ext << 1) + w_ext;
      data_plus = data_bytes + POS_BITS'(ROW_ALIGN - 1);
      base_prod = (height_cur - 1'b1) * width_cur;

      row_pos_nx = row_pos_ff + 1'b1;
      is_last = (file_row_ff == last_row_ff) && (column_ff == last_col_ff);

      if (req_fire) begin
         phase_in = phase_cur;
         hcount_in = hcount_cur;
         width_in = width_cur;
         height_in = height_cur;
         width_big_in = width_big_cur;
         height_big_in = height_big_cur;
         sig_ok_in = sig_ok_cur;

         case (phase_cur)
            PH_HEADER: begin
               hcount_in = hcount_cur + 1'b1;
               if (hcount_cur == SIG1_C) begin
                  sig_ok_in = (b == SIG_B);
               end
               if ((hcount_cur >= W_POS_C) && (hcount_cur < W_END_C)) begin
                  width_in = width_cur | w_shift[W_BITS-1:0];
                  width_big_in = width_big_cur | (|w_shift[31:W_BITS]);
               end
               if ((hcount_cur >= H_POS_C) && (hcount_cur < H_END_C)) begin
                  height_in = height_cur | h_shift[H_BITS-1:0];
                  height_big_in = height_big_cur | (|h_shift[31:H_BITS]);
               end
               if ((hcount_cur == SIG2_C) && (!sig_ok_cur || (b != SIG_M))) begin
                  phase_in = PH_IDLE;
                  parse_out.produced = 1'b1;
                  parse_out.item.status = STATUS_BAD_SIGNATURE;
               end else if (hcount_cur == HDR_LAST) begin
                  if (size_bad) begin
                     phase_in = PH_IDLE;
                     parse_out.produced = 1'b1;
                     parse_out.item.status = STATUS_BAD_SIZE;
                  end else begin
                     phase_in = PH_PIXELS;
                     column_in = '0;
                     file_row_in = '0;
                     row_pos_in = '0;
                     comp_in = COMP_BLUE;
                     data_bytes_in = data_bytes;
                     row_bytes_in = {data_plus[POS_BITS-1:2], 2'b00};
                     row_base_in = IDX_BITS'(base_prod);
                     last_col_in = width_cur - 1'b1;
                     last_row_in = height_cur - 1'b1;
                  end
               end
            end
            PH_PIXELS: begin
               if (row_pos_ff < data_bytes_ff) begin
                  case (comp_ff)
                     COMP_BLUE: begin
                        blue_in = b;
                        comp_in = COMP_GREEN;
                     end
                     COMP_GREEN: begin
                        green_in = b;
                        comp_in = COMP_RED;
                     end
                     COMP_RED: begin
                        comp_in = COMP_BLUE;
                        parse_out.produced = 1'b1;
                        parse_out.item.pixel_word = {ALPHA_OPAQUE, blue_ff, green_ff, b};
                        parse_out.item.pixel_index = row_base_ff + IDX_BITS'(column_ff);
                        parse_out.item.last_pixel = is_last;
                        column_in = column_ff + 1'b1;
                     end
                     default: begin
                        comp_in = COMP_BLUE;
                     end
                  endcase
               end
               // The final pixel ends the image; otherwise step through the row.
               if (parse_out.produced && is_last) begin
                  phase_in = PH_IDLE;
               end else if (row_pos_nx >= row_bytes_ff) begin
                  row_pos_in = '0;
                  column_in = '0;
                  comp_in = COMP_BLUE;
                  file_row_in = file_row_ff + 1'b1;
                  row_base_in = row_base_ff - IDX_BITS'(width_ff);
               end else begin
                  row_pos_in = row_pos_nx;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hcount_ff <= '0;
         width_ff <= '0;
         height_ff <= '0;
         width_big_ff <= 1'b0;
         height_big_ff <= 1'b0;
         sig_ok_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hcount_ff <= hcount_in;
         width_ff <= width_in;
         height_ff <= height_in;
         width_big_ff <= width_big_in;
         height_big_ff <= height_big_in;
         sig_ok_ff <= sig_ok_in;
      end
   end

   // Pixel walk registers; they are loaded before the pixel phase uses them.
   always_ff @(posedge clock) begin
      column_ff <= column_in;
      file_row_ff <= file_row_in;
      row_pos_ff <= row_pos_in;
      comp_ff <= comp_in;
      blue_ff <= blue_in;
      green_ff <= green_in;
      data_bytes_ff <= data_bytes_in;
      row_bytes_ff <= row_bytes_in;
      row_base_ff <= row_base_in;
      last_col_ff <= last_col_in;
      last_row_ff <= last_row_in;
   end

   `BMP24_ASSERT(a_error_stops_file, req_fire && parse_out.produced && (parse_out.item.status != STATUS_PIXEL) |=> phase_ff == PH_IDLE, "Error result did not stop the file")
   `BMP24_ASSERT(a_last_stops_file, req_fire && parse_out.produced && parse_out.item.last_pixel |=> phase_ff == PH_IDLE, "Final pixel did not end the image")
   `BMP24_ASSERT(a_row_pos_bound, phase_ff == PH_PIXELS |-> row_pos_ff < row_bytes_ff, "Row byte position ran past the padded row")
   `BMP24_ASSERT_ALWAYS(a_header_bound, phase_ff == PH_HEADER |-> hcount_ff < HEADER_BYTES, "Header count ran past the header")

endmodule

@@ test/bmp24_stream_decoder_tb.sv @@
`timescale 1ns / 1ps

module bmp24_stream_decoder_tb;
   import bmp24_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 1000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   bmp24_stream_decoder u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // Decoder state as the testbench sees it.
   phase_type dec_phase;
   int unsigned dec_hdr_count;
   logic [31:0] dec_width;
   logic [31:0] dec_height;
   logic [31:0] dec_column;
   logic [31:0] dec_row;
   logic [31:0] dec_row_pos;
   logic [7:0] dec_blue;
   logic [7:0] dec_green;
   logic dec_sig_ok;

   rsp_type pixel_queue[$];

   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int rsp_wait = 0;
   int cycle_count = 0;
   int fail_count = 0;
   int bytes_sent = 0;
   int files_sent = 0;
   int pixels_seen = 0;
   int errors_seen = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle limit, in case the decoder hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bmp24_stream_decoder verification failed");
         $finish;
      end
   end

   // Returns the parser to the start of a header.
   function automatic void decode_restart();
      dec_phase = PH_HEADER;
      dec_hdr_count = 0;
      dec_width = '0;
      dec_height = '0;
      dec_column = '0;
      dec_row = '0;
      dec_row_pos = '0;
      dec_blue = '0;
      dec_green = '0;
      dec_sig_ok = 1'b0;
   endfunction

   // Advances the decoder state by one byte and queues the result it causes.
   function automatic void decode_byte(input logic [7:0] value, input logic start);
      rsp_type r;
      logic [31:0] data_bytes;
      logic [31:0] row_bytes;
      logic [31:0] y;
      logic last;
      r = '0;
      if (start) decode_restart();
      if (dec_phase == PH_HEADER) begin
         if (dec_hdr_count == SIG_FIRST_POS) begin
            dec_sig_ok = (value == SIG_B);
         end else if (dec_hdr_count == SIG_SECOND_POS) begin
            if (!dec_sig_ok || value != SIG_M) begin
               dec_phase = PH_IDLE;
               r.status = STATUS_BAD_SIGNATURE;
               pixel_queue.push_back(r);
               return;
            end
         end else if (dec_hdr_count >= WIDTH_POS &&
                      dec_hdr_count < WIDTH_POS + FIELD_BYTES) begin
            dec_width |= 32'(value) << (8 * (dec_hdr_count - WIDTH_POS));
         end else if (dec_hdr_count >= HEIGHT_POS &&
                      dec_hdr_count < HEIGHT_POS + FIELD_BYTES) begin
            dec_height |= 32'(value) << (8 * (dec_hdr_count - HEIGHT_POS));
         end
         // The last header byte either rejects the size or opens the pixel rows.
         if (dec_hdr_count + 1 >= HEADER_BYTES) begin
            if (dec_width == 0 || dec_height == 0 ||
                dec_width > MAX_WIDTH || dec_height > MAX_HEIGHT) begin
               dec_phase = PH_IDLE;
               r.status = STATUS_BAD_SIZE;
               pixel_queue.push_back(r);
               return;
            end
            dec_phase = PH_PIXELS;
            dec_column = '0;
            dec_row = '0;
            dec_row_pos = '0;
            dec_blue = '0;
            dec_green = '0;
         end
         dec_hdr_count++;
      end else if (dec_phase == PH_PIXELS) begin
         data_bytes = dec_width * 3;
         row_bytes = (data_bytes + 3) & ~32'd3;
         if (dec_row_pos < data_bytes) begin
            case (comp_type'(dec_row_pos % 3))
               COMP_BLUE: dec_blue = value;
               COMP_GREEN: dec_green = value;
               default: begin
                  // File rows run bottom-up, so the first row lands at the bottom.
                  y = dec_height - 1 - dec_row;
                  last = (dec_row == dec_height - 1) && (dec_column == dec_width - 1);
                  r.status = STATUS_PIXEL;
                  r.pixel_word = {ALPHA_OPAQUE, dec_blue, dec_green, value};
                  r.pixel_index = IDX_BITS'(y * dec_width + dec_column);
                  r.last_pixel = last;
                  pixel_queue.push_back(r);
                  if (last) begin
                     dec_phase = PH_IDLE;
                     return;
                  end
                  dec_column++;
               end
            endcase
         end
         // Padding bytes only move the row position on.
         dec_row_pos++;
         if (dec_row_pos >= row_bytes) begin
            dec_row_pos = '0;
            dec_column = '0;
            dec_row++;
         end
      end
   endfunction

   // Result checking, and the receiver's stall draw after each accepted result.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_wait = $urandom_range(0, 6);
         if (pixel_queue.size() == 0) begin
            $error("unexpected result: status %0d word %h index %0d",
                   rsp_data.status, rsp_data.pixel_word, rsp_data.pixel_index);
            fail_count++;
         end else begin
            want = pixel_queue.pop_front();
            if (want.status == STATUS_PIXEL) pixels_seen++;
            else errors_seen++;
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.pixel_word !== want.pixel_word) begin
               $error("pixel_word: expected %h, got %h",
                      want.pixel_word, rsp_data.pixel_word);
               fail_count++;
            end
            if (rsp_data.pixel_index !== want.pixel_index) begin
               $error("pixel_index: expected %0d, got %0d",
                      want.pixel_index, rsp_data.pixel_index);
               fail_count++;
            end
            if (rsp_data.last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %0d, got %0d",
                      want.last_pixel, rsp_data.last_pixel);
               fail_count++;
            end
         end
      end
   end

   // Receiver stall: a long hold-off when asked for, otherwise the drawn wait.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (rsp_wait > 0 && !no_idle) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offers one request after a random gap (none while no_idle is set) and waits until it is taken.
   task automatic send_byte(input logic [7:0] value, input logic start);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: value, file_start: start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(value, start);
      bytes_sent++;
   endtask

   function automatic int image_bytes(input int w, input int h);
      return ((w * 3 + 3) & ~3) * h;
   endfunction

   // Sends a header followed by body_len random bytes; a negative length cuts the header.
   task automatic send_bmp(input logic [31:0] w, input logic [31:0] h, input logic [7:0] sig0,
                           input logic [7:0] sig1, input int body_len, input bit with_start);
      logic [7:0] b;
      for (int i = 0; i < HEADER_BYTES + body_len; i++) begin
         b = 8'($urandom);
         if (i == SIG_FIRST_POS) b = sig0;
         else if (i == SIG_SECOND_POS) b = sig1;
         else if (i >= WIDTH_POS && i < WIDTH_POS + FIELD_BYTES)
            b = w[8 * (i - WIDTH_POS) +: 8];
         else if (i >= HEIGHT_POS && i < HEIGHT_POS + FIELD_BYTES)
            b = h[8 * (i - HEIGHT_POS) +: 8];
         send_byte(b, with_start && i == 0);
      end
      files_sent++;
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
   endtask

   // Lets every queued result arrive, then waits with no requests offered.
   task automatic drain();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pixel_queue.size() != 0) begin
         $error("%0d results never arrived", pixel_queue.size());
         fail_count++;
         pixel_queue.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // A file that arrives after reset without a start flag.
   task automatic test_no_start_flag();
      send_bmp(2, 2, SIG_B, SIG_M, image_bytes(2, 2) + 2, 1'b0);
      drain();
   endtask

   // Bad signatures; the rest of each short file must be dropped.
   task automatic test_signature();
      send_bmp(3, 1, 8'h58, SIG_M, -44, 1'b1);
      send_bmp(3, 1, SIG_B, 8'h58, -44, 1'b1);
      send_bmp(3, 1, SIG_M, SIG_B, -44, 1'b1);
      send_bmp(3, 1, SIG_B, SIG_B, -44, 1'b1);
      drain();
   endtask

   // Zero and oversized sizes, then the first pixels of the largest accepted sizes.
   task automatic test_size_limits();
      send_bmp(0, 3, SIG_B, SIG_M, 1, 1'b1);
      send_bmp(3, 0, SIG_B, SIG_M, 1, 1'b1);
      send_bmp(MAX_WIDTH + 1, 1, SIG_B, SIG_M, 1, 1'b1);
      send_bmp(1, MAX_HEIGHT + 1, SIG_B, SIG_M, 1, 1'b1);
      send_bmp(32'h0100_0001, 1, SIG_B, SIG_M, 1, 1'b1);
      send_bmp(1, 32'hFFFF_FFFF, SIG_B, SIG_M, 1, 1'b1);
      drain();
      no_idle = 1'b1;
      send_bmp(MAX_WIDTH, 1, SIG_B, SIG_M, 30, 1'b1);
      send_bmp(1, MAX_HEIGHT, SIG_B, SIG_M, 40, 1'b1);
      no_idle = 1'b0;
      drain();
   endtask

   // Every amount of row padding, with trailing bytes after the last pixel.
   task automatic test_row_padding();
      for (int w = 1; w <= 4; w++) send_bmp(w, 2, SIG_B, SIG_M, image_bytes(w, 2) + 3, 1'b1);
      drain();
   endtask

   // A start flag in the header, in the pixels, and a few pixels into a full-size image.
   task automatic test_restart();
      send_bmp(5, 5, SIG_B, SIG_M, -30, 1'b1);
      send_bmp(3, 2, SIG_B, SIG_M, 10, 1'b1);
      no_idle = 1'b1;
      send_bmp(MAX_WIDTH, MAX_HEIGHT, SIG_B, SIG_M, 30, 1'b1);
      no_idle = 1'b0;
      send_bmp(2, 2, SIG_B, SIG_M, image_bytes(2, 2), 1'b1);
      drain();
   endtask

   // The receiver holds off while requests keep coming, so the input backs up.
   task automatic test_backpressure();
      no_idle = 1'b1;
      hold_request = 1'b1;
      send_bmp(8, 2, SIG_B, SIG_M, image_bytes(8, 2), 1'b1);
      no_idle = 1'b0;
      drain();
   endtask

   // Mostly well-formed small files, with broken ones and noise among them.
   task automatic test_random_files();
      int first_byte;
      int first_file;
      int kind;
      int w;
      int h;
      int full;
      bit with_start;
      first_byte = bytes_sent;
      first_file = files_sent;
      while (bytes_sent - first_byte < 100 || files_sent - first_file < 2) begin
         kind = $urandom_range(0, 9);
         with_start = $urandom_range(0, 7) != 0;
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 5);
         full = image_bytes(w, h);
         if (kind <= 6) begin
            if ($urandom_range(0, 5) == 0)
               send_bmp(w, h, SIG_B, SIG_M, $urandom_range(0, full - 1), with_start);
            else
               send_bmp(w, h, SIG_B, SIG_M, full + $urandom_range(0, 4), with_start);
         end else if (kind == 7) begin
            send_bmp(w, h, 8'($urandom), ($urandom_range(0, 1) == 0) ? SIG_M : 8'($urandom),
                     $urandom_range(0, 8), with_start);
         end else if (kind == 8) begin
            case ($urandom_range(0, 3))
               0: w = 0;
               1: h = 0;
               2: w = $urandom_range(MAX_WIDTH + 1, 65535);
               default: h = $urandom;
            endcase
            send_bmp(w, h, SIG_B, SIG_M, $urandom_range(0, 8), with_start);
         end else begin
            send_noise($urandom_range(1, 20));
         end
      end
      drain();
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      decode_restart();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_no_start_flag();
      test_signature();
      test_size_limits();
      test_row_padding();
      test_restart();
      test_backpressure();
      test_random_files();

      $display("Sent %0d request bytes in %0d files; checked %0d pixels and %0d error results.",
               bytes_sent, files_sent, pixels_seen, errors_seen);
      $display("Covered signature and size errors, padding, restarts and a long output hold-off.");
      if (fail_count == 0) begin
         $display("bmp24_stream_decoder verification clean");
      end else begin
         $display("bmp24_stream_decoder verification failed");
      end
      $finish;
   end

endmodule
